/* sv/oms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, codes and the result token type of the oligo mismatch search core.
package oms_pkg;

    // Payload and register widths.
    localparam int MODE_W        = 2;
    localparam int BASES_W       = 64;
    localparam int BASE_W        = 3;
    localparam int POS_W         = 32;
    localparam int OLIGO_INDEX_W = 6;
    localparam int CFG_LEN_W     = 6;
    localparam int MM_W          = 2;
    localparam int APB_DATA_W    = 32;
    localparam int PADDR_W       = 3;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BASE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;

    // Register indexes, decoded from the word address bit of paddr.
    localparam logic REG_OLIGO_LENGTH   = 1'b0;
    localparam logic REG_MAX_MISMATCHES = 1'b1;

    // Register reset values.
    localparam logic [CFG_LEN_W-1:0] LEN_RESET = 6'd20;
    localparam logic [MM_W-1:0]      MM_RESET  = 2'd3;

    // Control part of a window token as it travels down the cell chain.
    typedef struct packed {
        logic                     valid;
        logic                     found;
        logic [OLIGO_INDEX_W-1:0] best;
        logic [POS_W-1:0]         pos;
    } tok_t;

endpackage
`default_nettype wire

/* sv/oms_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// One cell of the probe chain: holds one probe and scores the passing window against it.
module oms_cell #(
    parameter int INDEX      = 0,
    parameter int MAX_LENGTH = 32,
    parameter int CNT_W      = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          load_en,
    input  logic [CNT_W-1:0]              load_idx,
    input  logic [2*MAX_LENGTH-1:0]       load_bases,
    input  logic [MAX_LENGTH-1:0]         care,
    input  logic [oms_pkg::MM_W-1:0]      max_mm,
    input  oms_pkg::tok_t                 tok_in,
    input  logic [2*MAX_LENGTH-1:0]       win_in,
    input  logic [MAX_LENGTH-1:0]         unk_in,
    input  logic [CNT_W-1:0]              cnt_in,
    output oms_pkg::tok_t                 tok_out,
    output logic [2*MAX_LENGTH-1:0]       win_out,
    output logic [MAX_LENGTH-1:0]         unk_out,
    output logic [CNT_W-1:0]              cnt_out
);
    import oms_pkg::*;

    localparam logic [CNT_W-1:0]         MY_INDEX = CNT_W'(INDEX);
    localparam logic [OLIGO_INDEX_W-1:0] MY_TAG   = OLIGO_INDEX_W'(INDEX);

    logic [2*MAX_LENGTH-1:0] probe_reg;
    logic [2*MAX_LENGTH-1:0] win_reg;
    logic [MAX_LENGTH-1:0]   unk_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [MAX_LENGTH-1:0]   diff;
    logic                    hit;
    tok_t                    tok_reg;
    tok_t                    tok_next;

    // The probe is written once, when the load count reaches this cell.
    always_ff @(posedge clk)
    begin
        if (load_en && (load_idx == MY_INDEX))
        begin
            probe_reg <= load_bases;
        end
    end

    // A position counts as a mismatch when it lies inside the length and the
    // bases differ or the window base was unknown.
    always_comb
    begin
        for (int i = 0; i < MAX_LENGTH; i++)
        begin
            diff[i] = care[i] & (unk_in[i] | (probe_reg[2*i +: 2] != win_in[2*i +: 2]));
        end
    end

    // Only probes loaded before the token entered the chain take part.
    assign hit = tok_in.valid && (MY_INDEX < cnt_in) && ($countones(diff) <= int'(max_mm));

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.best  = MY_TAG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_reg <= win_in;
            unk_reg <= unk_in;
            cnt_reg <= cnt_in;
        end
    end

    assign tok_out = tok_reg;
    assign win_out = win_reg;
    assign unk_out = unk_reg;
    assign cnt_out = cnt_reg;

endmodule
`default_nettype wire

/* sv/oligo_mismatch_search_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Top level of the oligo mismatch search core: window, registers and the probe cell chain.
// A genome base beat that completes a window gives its result beat through the entry stage
//   register and then the chain of MAX_PROBES cells, one register each.
// Throughput: one input beat per cycle of any mode, held back only by output stall.
// Reset: oligo_length 20, max_mismatches 3, probe count, window and position cleared;
//   probe contents are undefined until loaded and no clearing pass is needed.
module oligo_mismatch_search_core #(
    parameter int MAX_PROBES = 64,
    parameter int MAX_LENGTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [oms_pkg::PADDR_W-1:0]          paddr,
    input  logic [oms_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [oms_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [oms_pkg::MODE_W-1:0]           mode,
    input  logic [oms_pkg::BASES_W-1:0]          oligo_bases,
    input  logic [oms_pkg::BASE_W-1:0]           base,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [oms_pkg::POS_W-1:0]            hit_position,
    output logic [oms_pkg::OLIGO_INDEX_W-1:0]    oligo_index
);
    import oms_pkg::*;

    // Probe count must hold MAX_PROBES itself; the window holds two bits per base.
    localparam int CNT_W = $clog2(MAX_PROBES + 1);
    localparam int WIN_W = 2 * MAX_LENGTH;
    localparam logic [CFG_LEN_W-1:0] LEN_MAX = CFG_LEN_W'(MAX_LENGTH);

    // Configuration registers.
    logic [CFG_LEN_W-1:0] oligo_length_reg;
    logic [MM_W-1:0]      max_mismatches_reg;
    logic                 cfg_write;

    // Sequence state.
    logic [CNT_W-1:0]      probe_count_reg;
    logic [CNT_W-1:0]      probe_count_next;
    logic [WIN_W-1:0]      window_reg;
    logic [WIN_W-1:0]      window_next;
    logic [MAX_LENGTH-1:0] unknown_reg;
    logic [MAX_LENGTH-1:0] unknown_next;
    logic [POS_W-1:0]      bases_seen_reg;
    logic [POS_W-1:0]      bases_seen_next;

    // Entry stage feeding the first cell.
    tok_t                  tok0_reg;
    tok_t                  tok0_next;
    logic [WIN_W-1:0]      win0_reg;
    logic [MAX_LENGTH-1:0] unk0_reg;
    logic [CNT_W-1:0]      cnt0_reg;

    // Helper signals.
    logic                  adv;
    logic                  accept;
    logic                  store_room;
    logic                  load_en;
    logic [CFG_LEN_W-1:0]  eff_len;
    logic [CFG_LEN_W-1:0]  align_shift;
    logic [MAX_LENGTH-1:0] care;
    logic [WIN_W-1:0]      window_shift;
    logic [MAX_LENGTH-1:0] unknown_shift;
    logic [POS_W-1:0]      seen_inc;
    logic                  win_full;

    // Token chain between the cells; index g feeds cell g.
    tok_t                  tok_chain [MAX_PROBES+1];
    logic [WIN_W-1:0]      win_chain [MAX_PROBES+1];
    logic [MAX_LENGTH-1:0] unk_chain [MAX_PROBES+1];
    logic [CNT_W-1:0]      cnt_chain [MAX_PROBES+1];

    // ------------------------------------------------------------------
    // Configuration port. The register is picked by the word address bit;
    // writes take effect in the access phase.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oligo_length_reg   <= LEN_RESET;
            max_mismatches_reg <= MM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_OLIGO_LENGTH:   oligo_length_reg   <= pwdata[CFG_LEN_W-1:0];
                REG_MAX_MISMATCHES: max_mismatches_reg <= pwdata[MM_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_OLIGO_LENGTH:   prdata = APB_DATA_W'(oligo_length_reg);
            REG_MAX_MISMATCHES: prdata = APB_DATA_W'(max_mismatches_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. The whole chain moves together; it holds only while a
    // result beat sits at the end and the output side stalls. The last cell's
    // register doubles as the output register.
    // ------------------------------------------------------------------
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // ------------------------------------------------------------------
    // Effective window length and the mask of compared positions. A length of
    // zero acts as one; a length beyond the window acts as the full window.
    // ------------------------------------------------------------------
    always_comb
    begin
        eff_len = oligo_length_reg;
        if (eff_len == '0)
        begin
            eff_len = CFG_LEN_W'(1);
        end
        if (eff_len > LEN_MAX)
        begin
            eff_len = LEN_MAX;
        end
    end

    assign align_shift = LEN_MAX - eff_len;

    always_comb
    begin
        for (int i = 0; i < MAX_LENGTH; i++)
        begin
            care[i] = (CFG_LEN_W'(i) < eff_len);
        end
    end

    // ------------------------------------------------------------------
    // Window update. The newest base enters the top slot; an unknown base is
    // stored as zero with its unknown flag set.
    // ------------------------------------------------------------------
    always_comb
    begin
        window_shift                 = window_reg >> 2;
        window_shift[WIN_W-1 -: 2]   = base[2] ? 2'b00 : base[1:0];
        unknown_shift                = unknown_reg >> 1;
        unknown_shift[MAX_LENGTH-1]  = base[2];
    end

    // The position count saturates instead of wrapping.
    assign seen_inc = (bases_seen_reg == '1) ? bases_seen_reg : bases_seen_reg + POS_W'(1);
    assign win_full = (seen_inc >= POS_W'(eff_len));

    assign store_room = (probe_count_reg < CNT_W'(MAX_PROBES));
    assign load_en    = accept && (mode == MODE_LOAD) && store_room;

    always_comb
    begin
        probe_count_next = probe_count_reg;
        window_next      = window_reg;
        unknown_next     = unknown_reg;
        bases_seen_next  = bases_seen_reg;
        if (accept)
        begin
            unique case (mode)
                MODE_LOAD:
                begin
                    if (store_room)
                    begin
                        probe_count_next = probe_count_reg + CNT_W'(1);
                    end
                end
                MODE_BASE:
                begin
                    window_next     = window_shift;
                    unknown_next    = unknown_shift;
                    bases_seen_next = seen_inc;
                end
                MODE_START:
                begin
                    window_next     = '0;
                    unknown_next    = '0;
                    bases_seen_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_count_reg <= '0;
            window_reg      <= '0;
            unknown_reg     <= '0;
            bases_seen_reg  <= '0;
        end
        else
        begin
            probe_count_reg <= probe_count_next;
            window_reg      <= window_next;
            unknown_reg     <= unknown_next;
            bases_seen_reg  <= bases_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Entry stage. A genome base beat that completes a window launches a token
    // carrying the window aligned so that its oldest base sits in slot zero,
    // the window start offset, and a snapshot of the probe count, so that
    // probes loaded later do not take part in this window's search.
    // ------------------------------------------------------------------
    always_comb
    begin
        tok0_next.valid = accept && (mode == MODE_BASE) && win_full;
        tok0_next.found = 1'b0;
        tok0_next.best  = '0;
        tok0_next.pos   = seen_inc - POS_W'(eff_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
        end
        else if (adv)
        begin
            tok0_reg <= tok0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win0_reg <= window_shift >> {align_shift, 1'b0};
            unk0_reg <= unknown_shift >> align_shift;
            cnt0_reg <= probe_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. Each cell owns one probe, scores the token passing through
    // it, and marks itself as the best hit when it matches; since tokens pass
    // the cells in rising index order, the highest matching index wins.
    // ------------------------------------------------------------------
    assign tok_chain[0] = tok0_reg;
    assign win_chain[0] = win0_reg;
    assign unk_chain[0] = unk0_reg;
    assign cnt_chain[0] = cnt0_reg;

    for (genvar g = 0; g < MAX_PROBES; g++)
    begin : g_cell
        oms_cell #(
            .INDEX      (g),
            .MAX_LENGTH (MAX_LENGTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .load_en    (load_en),
            .load_idx   (probe_count_reg),
            .load_bases (oligo_bases[WIN_W-1:0]),
            .care       (care),
            .max_mm     (max_mismatches_reg),
            .tok_in     (tok_chain[g]),
            .win_in     (win_chain[g]),
            .unk_in     (unk_chain[g]),
            .cnt_in     (cnt_chain[g]),
            .tok_out    (tok_chain[g+1]),
            .win_out    (win_chain[g+1]),
            .unk_out    (unk_chain[g+1]),
            .cnt_out    (cnt_chain[g+1])
        );
    end

    // A token that leaves the chain with a hit is a result beat.
    assign out_valid    = tok_chain[MAX_PROBES].valid && tok_chain[MAX_PROBES].found;
    assign hit_position = tok_chain[MAX_PROBES].pos;
    assign oligo_index  = tok_chain[MAX_PROBES].best;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        probe_count_reg <= CNT_W'(MAX_PROBES))
        else $error("probe count beyond store size");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        probe_count_reg >= $past(probe_count_reg))
        else $error("probe count decreased");

    a_seen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (bases_seen_reg == '1) && !(accept && (mode == MODE_START))
        |=> (bases_seen_reg == '1))
        else $error("position count wrapped");

    a_hit_loaded_probe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(oligo_index) < int'(cnt_chain[MAX_PROBES])))
        else $error("hit reported for a probe not loaded before the window");
`endif

endmodule
`default_nettype wire
